>>> hdl/sparse_coordinate_value_store_defines.svh
// Assertion macros for the store RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SPARSE_COORDINATE_VALUE_STORE_DEFINES_SVH
`define SPARSE_COORDINATE_VALUE_STORE_DEFINES_SVH

// Same-cycle implication.
`define SCVS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scvs same-cycle check failed");

// Next-cycle implication.
`define SCVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scvs next-cycle check failed");

`endif

>>> hdl/scvs_pkg.sv
`timescale 1ns / 1ps

package scvs_pkg;

    // Default sizes.
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_INDEX_BITS = 16;

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int VALUE_W = 64;
    localparam int COUNT_OUT_W = 7;

    // Answer for a key that is not present: the double -100000.0.
    localparam logic [VALUE_W-1:0] MISS_PATTERN = 64'hC0F8_6A00_0000_0000;
    // Everything but the sign bit; both signed zeros count as zero.
    localparam logic [VALUE_W-1:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

    // Operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Status codes.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                   found;
        logic [VALUE_W-1:0]     read_value;
        logic                   status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    // Write strobes for the slot memory.
    typedef struct packed {
        logic key_we;
        logic val_we;
    } slot_we_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

>>> hdl/scvs_chan_if.sv
`timescale 1ns / 1ps

// Valid/ready channel carrying one payload per transfer.
interface scvs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/scvs_slot_ram.sv
`timescale 1ns / 1ps

module scvs_slot_ram #(
    parameter int CAPACITY = scvs_pkg::DEF_CAPACITY,
    parameter int KEY_W    = 2 * scvs_pkg::DEF_INDEX_BITS
) (
    input  logic                        clk,
    input  scvs_pkg::slot_we_t          we,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [KEY_W:0]              key_wdata,
    input  logic [scvs_pkg::VALUE_W-1:0] val_wdata,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output logic [KEY_W:0]              key_rdata,
    output logic [scvs_pkg::VALUE_W-1:0] val_rdata
);
    import scvs_pkg::*;

    // Key word: valid flag on top of the packed (row, col) key.
    logic [KEY_W:0]       key_mem [CAPACITY];
    logic [VALUE_W-1:0]   val_mem [CAPACITY];

    // Key array: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we.key_we)
        begin
            key_mem[wr_addr] <= key_wdata;
        end
        key_rdata <= key_mem[rd_addr];
    end

    // Value array: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we.val_we)
        begin
            val_mem[wr_addr] <= val_wdata;
        end
        val_rdata <= val_mem[rd_addr];
    end

endmodule

>>> hdl/sparse_coordinate_value_store.sv
`timescale 1ns / 1ps
// Channel  Role    Payload
// -------  ------  ---------------------------------------------
// req      sink    opcode, row, col, write_value
// rsp      source  found, read_value, status, entry_count
//
// An access takes the request in IDLE, steps the slot read port over every
// slot in SCAN, drains the last compare in DRAIN, and commits the update and
// loads the result in COMMIT.
// After reset a clearing pass over every slot marks each slot free first.
// A request may be taken while the previous result still waits; the commit
// step then holds until that result has been transferred.

module sparse_coordinate_value_store #(
    parameter int CAPACITY   = scvs_pkg::DEF_CAPACITY,
    parameter int INDEX_BITS = scvs_pkg::DEF_INDEX_BITS
) (
    input logic       clk,
    input logic       rst_n,
    scvs_chan_if.sink   req,
    scvs_chan_if.source rsp
);
    import scvs_pkg::*;
`include "sparse_coordinate_value_store_defines.svh"

    // Only the low index bits of row and col form the key.
    localparam int IB_EFF  = (INDEX_BITS < COORD_W) ? INDEX_BITS : COORD_W;
    localparam int KEY_W   = 2 * IB_EFF;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]   scan_idx_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               hit_found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [VALUE_W-1:0] hit_value_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    logic               out_valid_reg;
    rsp_t               out_reg;
    rsp_t               out_next;

    slot_we_t           mem_we;
    logic [IDX_W-1:0]   mem_wr_addr;
    logic [KEY_W:0]     mem_key_wdata;
    logic [VALUE_W-1:0] mem_val_wdata;
    logic [KEY_W:0]     mem_key_rdata;
    logic [VALUE_W-1:0] mem_val_rdata;

    logic               accept;
    logic               commit_fire;
    logic               scan_last;
    logic               value_zero;
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

    scvs_slot_ram #(
        .CAPACITY (CAPACITY),
        .KEY_W    (KEY_W)
    ) u_slot_ram (
        .clk       (clk),
        .we        (mem_we),
        .wr_addr   (mem_wr_addr),
        .key_wdata (mem_key_wdata),
        .val_wdata (mem_val_wdata),
        .rd_addr   (scan_idx_reg),
        .key_rdata (mem_key_rdata),
        .val_rdata (mem_val_rdata)
    );

    assign scan_last  = (scan_idx_reg == LAST_IDX);
    assign value_zero = ((value_reg & MAG_MASK) == '0);
    assign count_ext  = {{COUNT_OUT_W{1'b0}}, count_next};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshakes, memory writes and the commit decision.
    always_comb
    begin
        req.ready     = (state_reg == ST_IDLE);
        accept        = req.valid && req.ready;
        commit_fire   = (state_reg == ST_COMMIT) && (!out_valid_reg || rsp.ready);
        mem_we        = '0;
        mem_wr_addr   = scan_idx_reg;
        mem_key_wdata = '0;
        mem_val_wdata = value_reg;
        count_next    = count_reg;
        out_next.found       = hit_found_reg;
        out_next.read_value  = hit_found_reg ? hit_value_reg : MISS_PATTERN;
        out_next.status      = STATUS_DONE;
        out_next.entry_count = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Mark the slot free.
                mem_we.key_we = 1'b1;
            end
            ST_COMMIT:
            begin
                if (op_reg == OP_WRITE)
                begin
                    if (hit_found_reg)
                    begin
                        mem_wr_addr = hit_idx_reg;
                        if (value_zero)
                        begin
                            // Delete the entry.
                            mem_we.key_we = commit_fire;
                            mem_key_wdata = {1'b0, key_reg};
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            // Update the stored value in place.
                            mem_we.val_we = commit_fire;
                        end
                    end
                    else if (!value_zero)
                    begin
                        if (free_found_reg)
                        begin
                            // Insert into the lowest free slot.
                            mem_wr_addr   = free_idx_reg;
                            mem_we.key_we = commit_fire;
                            mem_we.val_we = commit_fire;
                            mem_key_wdata = {1'b1, key_reg};
                            count_next    = count_reg + 1'b1;
                        end
                        else
                        begin
                            out_next.status = STATUS_FULL;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        out_next.entry_count = count_ext[COUNT_OUT_W-1:0];
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= (state_reg == ST_SCAN);
            if ((state_reg == ST_CLEAR) || (state_reg == ST_SCAN))
            begin
                scan_idx_reg <= scan_last ? '0 : scan_idx_reg + 1'b1;
            end
            if (commit_fire)
            begin
                count_reg <= count_next;
            end
            if (commit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture, compare stage and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (accept)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmp_valid_reg)
        begin
            // The first matching valid slot is the hit; the first empty one is free.
            if (mem_key_rdata[KEY_W])
            begin
                if (!hit_found_reg && (mem_key_rdata[KEY_W-1:0] == key_reg))
                begin
                    hit_found_reg <= 1'b1;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx_reg;
        if (accept)
        begin
            op_reg    <= req.payload.opcode;
            key_reg   <= {req.payload.row[IB_EFF-1:0], req.payload.col[IB_EFF-1:0]};
            value_reg <= req.payload.write_value;
        end
        if (cmp_valid_reg && !accept)
        begin
            if (mem_key_rdata[KEY_W])
            begin
                if (!hit_found_reg && (mem_key_rdata[KEY_W-1:0] == key_reg))
                begin
                    hit_idx_reg   <= cmp_idx_reg;
                    hit_value_reg <= mem_val_rdata;
                end
            end
            else if (!free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
        if (commit_fire)
        begin
            out_reg <= out_next;
        end
    end

    // Checks.
    `SCVS_ASSERT_NEXT(a_insert_counts_up,
        commit_fire && mem_we.key_we && mem_key_wdata[KEY_W],
        count_reg == $past(count_reg) + 1'b1)
    `SCVS_ASSERT_NEXT(a_delete_counts_down,
        commit_fire && mem_we.key_we && !mem_key_wdata[KEY_W],
        count_reg == $past(count_reg) - 1'b1)
    `SCVS_ASSERT_NOW(a_full_status_at_capacity,
        rsp.valid && (rsp.payload.status == STATUS_FULL),
        count_reg == FULL_COUNT)
    `SCVS_ASSERT_NOW(a_compare_only_in_scan,
        cmp_valid_reg,
        (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))

endmodule

>>> test/sparse_coordinate_value_store_test.sv
`timescale 1ns / 1ps

module sparse_coordinate_value_store_test;

    import scvs_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int INDEX_BITS   = DEF_INDEX_BITS;
    localparam int KEY_W        = 2 * INDEX_BITS;
    localparam int PAIR_W       = 2 * COORD_W;
    localparam int ACCESS_DELAY = CAPACITY + 3;

    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned CYCLE_LIMIT  = 800000;

    // A few double patterns used by the directed rows and the value picker.
    localparam logic [VALUE_W-1:0] ONE_POS   = 64'h3FF0_0000_0000_0000;
    localparam logic [VALUE_W-1:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [VALUE_W-1:0] TINY_POS  = 64'h0000_0000_0000_0001;
    localparam logic [VALUE_W-1:0] TINY_NEG  = 64'h8000_0000_0000_0001;

    typedef enum
    {
        FILL_PHASE,
        MIX_PHASE,
        DRAIN_PHASE
    } phase_t;

    typedef struct
    {
        req_t access;
        bit   typed;
        rsp_t answer;
    } directed_row_t;

    logic clk;
    logic rst_n;

    scvs_chan_if #(.payload_t(req_t)) access_ch ();
    scvs_chan_if #(.payload_t(rsp_t)) answer_ch ();

    sparse_coordinate_value_store #(
        .CAPACITY(CAPACITY),
        .INDEX_BITS(INDEX_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(access_ch),
        .rsp(answer_ch)
    );

    // Shadow copy of the store.
    bit                 slot_used [CAPACITY];
    logic [KEY_W-1:0]   slot_coord [CAPACITY];
    logic [VALUE_W-1:0] slot_data [CAPACITY];
    int unsigned        held;

    rsp_t          awaited_answers [$];
    directed_row_t directed_rows [$];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned sent_random;
    int unsigned checked_count;
    int unsigned read_count;
    int unsigned write_count;
    int unsigned hit_count;
    int unsigned delete_count;
    int unsigned drop_count;
    int unsigned peak_held;
    bit          no_idle;
    bit          hold_request;
    logic        hold_results;

    always #6 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_answers.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Looks the key up in the shadow store, then applies the write if there is one.
    function automatic rsp_t apply_access(input req_t r);
        logic [KEY_W-1:0] coord;
        int               hit_slot;
        int               free_slot;
        bit               zero_write;
        rsp_t             a;
        coord = {r.row[INDEX_BITS-1:0], r.col[INDEX_BITS-1:0]};
        hit_slot = -1;
        free_slot = -1;
        for (int s = 0; s < CAPACITY; s++)
        begin
            if (slot_used[s])
            begin
                if (hit_slot < 0 && slot_coord[s] == coord)
                    hit_slot = s;
            end
            else if (free_slot < 0)
            begin
                free_slot = s;
            end
        end

        a.found = (hit_slot >= 0);
        a.read_value = (hit_slot >= 0) ? slot_data[hit_slot] : MISS_PATTERN;
        a.status = STATUS_DONE;
        zero_write = ((r.write_value & MAG_MASK) == '0);
        if (hit_slot >= 0)
            hit_count++;

        if (r.opcode == OP_WRITE)
        begin
            write_count++;
            if (hit_slot >= 0)
            begin
                if (zero_write)
                begin
                    slot_used[hit_slot] = 1'b0;
                    if (held > 0)
                        held--;
                    delete_count++;
                end
                else
                begin
                    slot_data[hit_slot] = r.write_value;
                end
            end
            else if (!zero_write)
            begin
                if (free_slot >= 0)
                begin
                    slot_used[free_slot] = 1'b1;
                    slot_coord[free_slot] = coord;
                    slot_data[free_slot] = r.write_value;
                    held++;
                end
                else
                begin
                    a.status = STATUS_FULL;
                    drop_count++;
                end
            end
        end
        else
        begin
            read_count++;
        end

        if (held > peak_held)
            peak_held = held;
        a.entry_count = held[COUNT_OUT_W-1:0];
        return a;
    endfunction

    // Offers one access and waits for its transfer; entered and left at a rising edge.
    task automatic send_access(input req_t r, input bit typed, input rsp_t typed_answer);
        int unsigned gap;
        rsp_t        predicted;
        gap = 0;
        while (!no_idle && $urandom_range(99) < 34)
            gap++;
        if (gap != 0)
        begin
            access_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        access_ch.valid <= 1'b1;
        access_ch.payload <= r;
        do
            @(posedge clk);
        while (!(access_ch.valid && access_ch.ready));
        predicted = apply_access(r);
        awaited_answers.push_back(typed ? typed_answer : predicted);
    endtask

    // Stops offering and waits until every awaited result has been transferred.
    task automatic pause_until_drained();
        access_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_answers.size() != 0)
            @(posedge clk);
    endtask

    function automatic req_t access_of(input logic op, input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] col,
                                       input logic [VALUE_W-1:0] value);
        req_t r;
        r.opcode = op;
        r.row = row;
        r.col = col;
        r.write_value = value;
        return r;
    endfunction

    function automatic rsp_t answer_of(input logic found, input logic [VALUE_W-1:0] value,
                                       input logic status,
                                       input logic [COUNT_OUT_W-1:0] count);
        rsp_t a;
        a.found = found;
        a.read_value = value;
        a.status = status;
        a.entry_count = count;
        return a;
    endfunction

    function automatic void add_row(input req_t r, input bit typed, input rsp_t a);
        directed_row_t d;
        d.access = r;
        d.typed = typed;
        d.answer = a;
        directed_rows.push_back(d);
    endfunction

    // Index with a bias toward both ends of the range.
    function automatic logic [COORD_W-1:0] pick_index();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return COORD_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Either signed zero, or a nonzero pattern with a bias toward the odd ones.
    function automatic logic [VALUE_W-1:0] pick_value(input bit zero);
        logic [VALUE_W-1:0] v;
        if (zero)
            return $urandom_range(1) ? NEG_ZERO : '0;
        case ($urandom_range(9))
            0: v = QUIET_NAN;
            1: v = ALL_ONES;
            2: v = MISS_PATTERN;
            3: v = TINY_POS;
            4: v = TINY_NEG;
            default: v = {$urandom, $urandom};
        endcase
        if ((v & MAG_MASK) == '0)
            v = TINY_POS;
        return v;
    endfunction

    // One phase of random accesses over a pool of keys picked at its start.
    task automatic run_phase(input phase_t kind, input int unsigned length);
        logic [PAIR_W-1:0] pool [$];
        logic [PAIR_W-1:0] present [$];
        logic [PAIR_W-1:0] coord;
        req_t              r;
        int unsigned       draw;
        repeat ((kind == FILL_PHASE) ? 90 : 12)
            pool.push_back({pick_index(), pick_index()});

        repeat (length)
        begin
            draw = $urandom_range(99);
            coord = pool[$urandom_range(pool.size() - 1)];
            r.opcode = OP_WRITE;
            r.write_value = pick_value(1'b0);
            if (draw < 8)
            begin
                // Noise: any key, any operation.
                coord = {pick_index(), pick_index()};
                r.opcode = $urandom_range(1) ? OP_WRITE : OP_READ;
                r.write_value = pick_value($urandom_range(3) == 0);
            end
            else
            begin
                case (kind)
                    FILL_PHASE:
                    begin
                        if (draw < 18)
                            r.opcode = OP_READ;
                        else if (draw >= 95)
                            r.write_value = pick_value(1'b1);
                    end
                    MIX_PHASE:
                    begin
                        if (draw < 40)
                            r.opcode = OP_READ;
                        else if (draw >= 82)
                            r.write_value = pick_value(1'b1);
                    end
                    default:
                    begin
                        // Mostly deletes of keys that are held right now.
                        present.delete();
                        for (int s = 0; s < CAPACITY; s++)
                        begin
                            if (slot_used[s])
                                present.push_back(slot_coord[s]);
                        end
                        if (present.size() != 0 && $urandom_range(4) != 0)
                            coord = present[$urandom_range(present.size() - 1)];
                        if (draw < 30)
                            r.opcode = OP_READ;
                        else if (draw < 95)
                            r.write_value = pick_value(1'b1);
                    end
                endcase
            end
            if (r.opcode == OP_READ)
                r.write_value = {$urandom, $urandom};
            r.row = coord[PAIR_W-1:COORD_W];
            r.col = coord[COORD_W-1:0];
            send_access(r, 1'b0, '0);
            sent_random++;
        end
    endtask

    // Result side: ready at random, with one long hold-off.
    always @(posedge clk)
    begin
        answer_ch.ready <= !hold_results && (no_idle || $urandom_range(99) >= 34);
    end

    initial
    begin
        hold_results = 1'b0;
        while (!hold_request)
            @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Compare every result transfer with the oldest awaited answer.
    always @(posedge clk)
    begin
        rsp_t got;
        rsp_t want;
        if (rst_n && answer_ch.valid && answer_ch.ready)
        begin
            got = answer_ch.payload;
            checked_count++;
            if (awaited_answers.size() == 0)
            begin
                flag_mismatch("result with nothing awaited", got.read_value, '0);
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (got.found !== want.found)
                    flag_mismatch("found", got.found, want.found);
                if (got.read_value !== want.read_value)
                    flag_mismatch("read_value", got.read_value, want.read_value);
                if (got.status !== want.status)
                    flag_mismatch("status", got.status, want.status);
                if (got.entry_count !== want.entry_count)
                    flag_mismatch("entry_count", got.entry_count, want.entry_count);
            end
        end
    end

    initial
    begin
        int unsigned phase_index;
        int unsigned phase_len;
        phase_t      kind;
        clk = 1'b0;
        rst_n = 1'b0;
        access_ch.valid = 1'b0;
        access_ch.payload = '0;
        answer_ch.ready = 1'b0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        sent_random = 0;
        checked_count = 0;
        held = 0;
        peak_held = 0;
        foreach (slot_used[s])
            slot_used[s] = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: empty store, both index extremes, signed zeros, deletes,
        // zero writes to absent keys, NaN and the miss pattern stored as data.
        add_row(access_of(OP_READ, 16'h0000, 16'h0000, ALL_ONES), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd0));
        add_row(access_of(OP_WRITE, 16'h0000, 16'h0000, ONE_POS), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd1));
        add_row(access_of(OP_READ, 16'h0000, 16'h0000, ALL_ONES), 1'b1,
                answer_of(1'b1, ONE_POS, STATUS_DONE, 7'd1));
        add_row(access_of(OP_WRITE, 16'hFFFF, 16'hFFFF, ALL_ONES), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd2));
        add_row(access_of(OP_READ, 16'hFFFF, 16'hFFFF, '0), 1'b1,
                answer_of(1'b1, ALL_ONES, STATUS_DONE, 7'd2));
        add_row(access_of(OP_WRITE, 16'h0000, 16'hFFFF, NEG_ZERO), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd2));
        add_row(access_of(OP_WRITE, 16'hFFFF, 16'h0000, '0), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd2));
        add_row(access_of(OP_READ, 16'h0000, 16'hFFFF, '0), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd2));
        add_row(access_of(OP_WRITE, 16'h0000, 16'h0000, '0), 1'b1,
                answer_of(1'b1, ONE_POS, STATUS_DONE, 7'd1));
        add_row(access_of(OP_READ, 16'h0000, 16'h0000, '0), 1'b1,
                answer_of(1'b0, MISS_PATTERN, STATUS_DONE, 7'd1));
        add_row(access_of(OP_WRITE, 16'hFFFF, 16'hFFFF, NEG_ZERO), 1'b1,
                answer_of(1'b1, ALL_ONES, STATUS_DONE, 7'd0));
        add_row(access_of(OP_WRITE, 16'h0001, 16'h0002, MISS_PATTERN), 1'b0, '0);
        add_row(access_of(OP_READ, 16'h0001, 16'h0002, '0), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h0001, 16'h0002, TINY_POS), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h0002, 16'h0001, QUIET_NAN), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h0000, 16'h0000, TINY_NEG), 1'b0, '0);
        add_row(access_of(OP_READ, 16'h0002, 16'h0001, ALL_ONES), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h0001, 16'h0002, NEG_ZERO), 1'b0, '0);
        add_row(access_of(OP_READ, 16'h0001, 16'h0002, '0), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h0000, 16'h0000, ALL_ONES), 1'b0, '0);
        add_row(access_of(OP_READ, 16'hAAAA, 16'h5555, '0), 1'b0, '0);
        add_row(access_of(OP_WRITE, 16'h5555, 16'hAAAA, 64'h5555_5555_5555_5555), 1'b0, '0);
        add_row(access_of(OP_READ, 16'h5555, 16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA), 1'b0, '0);

        foreach (directed_rows[i])
            send_access(directed_rows[i].access, directed_rows[i].typed,
                        directed_rows[i].answer);
        pause_until_drained();

        // Random phases: fill past capacity, mix, drain, mix, and around again.
        // The second phase runs with no idling on either side; the fourth
        // starts the long hold-off on the result side.
        phase_index = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            case (phase_index % 4)
                0: kind = FILL_PHASE;
                2: kind = DRAIN_PHASE;
                default: kind = MIX_PHASE;
            endcase
            if (kind == DRAIN_PHASE)
                pause_until_drained();
            no_idle = (phase_index == 1);
            if (phase_index == 3)
                hold_request = 1'b1;
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_ITEMS - sent_random)
                phase_len = RANDOM_ITEMS - sent_random;
            run_phase(kind, phase_len);
            phase_index++;
        end
        no_idle = 1'b0;

        // Wait for the last results, then a quiet window for stray transfers.
        access_ch.valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(posedge clk);
        repeat (3 * ACCESS_DELAY) @(posedge clk);

        $display("Covered %0d reads and %0d writes with %0d hits, %0d deletes and %0d dropped",
                 read_count, write_count, hit_count, delete_count, drop_count);
        $display("inserts on a full store; %0d results checked, peak of %0d entries held.",
                 checked_count, peak_held);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
